// ----- rtl/sud64_pkg.sv -----
// Shared types and constants of the 64-bit restoring divider.
// Used by sud64_cell, sud64_ctrl and signed_unsigned_divider_64_core; no dependencies.
`default_nettype none

package sud64_pkg;

   localparam int DATA_WIDTH      = 64;
   localparam int OP_WIDTH        = 2;
   localparam int DIV_CELL_WIDTH  = 8;
   localparam int STEP_COUNT_BITS = $clog2(DATA_WIDTH);

   localparam logic [OP_WIDTH-1:0] OP_UNSIGNED_QUOT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_UNSIGNED_REM  = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SIGNED_QUOT   = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_SIGNED_REM    = 2'd3;

   // Per-cycle command that every cell of the chain receives.
   typedef struct packed {
      logic load;
      logic step;
      logic fits;
   } cell_ctrl_type;

   // What the top cell of the chain reports back to the controller.
   typedef struct packed {
      logic rem_msb;
      logic borrow;
   } chain_status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIX  = 3'b100
   } div_state_type;

endpackage

`default_nettype wire

// ----- rtl/signed_unsigned_divider_64_core.sv -----
// Top level of the 64-bit signed/unsigned restoring divider.
// Depends on sud64_pkg, sud64_cell and sud64_ctrl.
`default_nettype none

// Divides a 64-bit dividend by a 64-bit divisor and returns one 64-bit beat: the
// unsigned or signed quotient or remainder, chosen by req_tuser. Signed operations
// divide magnitudes; the quotient is negated when the operand signs differ and the
// remainder takes the sign of the dividend. A zero divisor returns zero with the
// divide-by-zero flag set, and the most negative value over -1 wraps. The divider takes
// one item at a time: the cycle in which it is accepted loads the operands, a chain of
// CELL_WIDTH-bit slices then produces one quotient bit per cycle with a borrow that
// ripples across the slices, and the fix-up state negates and registers the answer. A
// zero divisor skips the 64 steps and goes from acceptance straight to the fix-up state.
// A new beat is accepted once the answer is registered, even while that answer still
// waits for rsp_tready; the fix-up state of the new beat then stalls until the waiting
// answer is taken.

module signed_unsigned_divider_64_core
   import sud64_pkg::*;
#(
   parameter int CELL_WIDTH = DIV_CELL_WIDTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,  // dividend [63:0], divisor [127:64]
   input  wire logic [1:0]    req_tuser,  // operation [1:0]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,  // answer [63:0]
   output logic [0:0]         rsp_tuser   // divide_by_zero [0]
);

   localparam int NUM_CELLS = DATA_WIDTH / CELL_WIDTH;

   cell_ctrl_type         cell_ctrl;
   chain_status_type      chain_status;
   logic [DATA_WIDTH-1:0] load_num;
   logic [DATA_WIDTH-1:0] load_den;
   logic [DATA_WIDTH-1:0] rem_word;
   logic [DATA_WIDTH-1:0] quo_word;
   logic [NUM_CELLS-1:0]  rem_msb;
   logic [NUM_CELLS-1:0]  quo_msb;
   logic [NUM_CELLS-1:0]  borrow;
   logic                  dbz_flag;

   sud64_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_operation      (req_tuser),
      .req_dividend       (req_tdata[63:0]),
      .req_divisor        (req_tdata[127:64]),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_answer         (rsp_tdata),
      .rsp_divide_by_zero (dbz_flag),
      .chain_status       (chain_status),
      .rem_word           (rem_word),
      .quo_word           (quo_word),
      .cell_ctrl          (cell_ctrl),
      .load_num           (load_num),
      .load_den           (load_den)
   );

   assign rsp_tuser[0] = dbz_flag;

   // The top quotient bit shifts into the bottom of the remainder, and the new
   // quotient bit shifts into the bottom of the dividend/quotient register.
   for (genvar gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      logic rem_in_bit;
      logic quo_in_bit;
      logic borrow_in_bit;
      if (gi == 0) begin : g_first
         assign rem_in_bit    = quo_msb[NUM_CELLS-1];
         assign quo_in_bit    = cell_ctrl.fits;
         assign borrow_in_bit = 1'b0;
      end else begin : g_next
         assign rem_in_bit    = rem_msb[gi-1];
         assign quo_in_bit    = quo_msb[gi-1];
         assign borrow_in_bit = borrow[gi-1];
      end
      sud64_cell #(
         .CELL_WIDTH (CELL_WIDTH)
      ) u_cell (
         .clock        (clock),
         .cell_ctrl    (cell_ctrl),
         .load_num     (load_num[gi*CELL_WIDTH +: CELL_WIDTH]),
         .load_den     (load_den[gi*CELL_WIDTH +: CELL_WIDTH]),
         .rem_shift_in (rem_in_bit),
         .quo_shift_in (quo_in_bit),
         .borrow_in    (borrow_in_bit),
         .rem_msb_out  (rem_msb[gi]),
         .quo_msb_out  (quo_msb[gi]),
         .borrow_out   (borrow[gi]),
         .rem_out      (rem_word[gi*CELL_WIDTH +: CELL_WIDTH]),
         .quo_out      (quo_word[gi*CELL_WIDTH +: CELL_WIDTH])
      );
   end

   assign chain_status.rem_msb = rem_msb[NUM_CELLS-1];
   assign chain_status.borrow  = borrow[NUM_CELLS-1];

`ifndef SYNTH
   a_dbz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && dbz_flag) |-> (rsp_tdata == '0))
      else $error("divide by zero returned a nonzero answer");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("divider took a beat while a division was under way");

   a_step_when_busy: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.step |-> (!req_tready && !cell_ctrl.load))
      else $error("cell chain stepped while the divider was idle or loading");
`endif

endmodule

`default_nettype wire

// ----- rtl/sud64_cell.sv -----
// One slice of the divider chain: partial remainder, dividend/quotient and divisor bits.
// Depends on sud64_pkg for the cell command struct.
`default_nettype none

module sud64_cell
   import sud64_pkg::*;
#(
   parameter int CELL_WIDTH = DIV_CELL_WIDTH
) (
   input  wire logic                  clock,
   input  wire cell_ctrl_type         cell_ctrl,
   input  wire logic [CELL_WIDTH-1:0] load_num,
   input  wire logic [CELL_WIDTH-1:0] load_den,
   input  wire logic                  rem_shift_in,
   input  wire logic                  quo_shift_in,
   input  wire logic                  borrow_in,
   output logic                       rem_msb_out,
   output logic                       quo_msb_out,
   output logic                       borrow_out,
   output logic [CELL_WIDTH-1:0]      rem_out,
   output logic [CELL_WIDTH-1:0]      quo_out
);

   logic [CELL_WIDTH-1:0] rem_ff, rem_in;
   logic [CELL_WIDTH-1:0] quo_ff, quo_in;
   logic [CELL_WIDTH-1:0] den_ff, den_in;
   logic [CELL_WIDTH:0]   rem_cat;
   logic [CELL_WIDTH:0]   quo_cat;
   logic [CELL_WIDTH:0]   diff_ext;

   always_comb begin
      rem_cat  = {rem_ff, rem_shift_in};
      quo_cat  = {quo_ff, quo_shift_in};
      // The borrow ripples from the low slice to the high slice within the cycle.
      diff_ext = {1'b0, rem_cat[CELL_WIDTH-1:0]} - {1'b0, den_ff}
                 - {{CELL_WIDTH{1'b0}}, borrow_in};
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      if (cell_ctrl.load) begin
         rem_in = '0;
         quo_in = load_num;
         den_in = load_den;
      end else if (cell_ctrl.step) begin
         rem_in = cell_ctrl.fits ? diff_ext[CELL_WIDTH-1:0] : rem_cat[CELL_WIDTH-1:0];
         quo_in = quo_cat[CELL_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rem_msb_out = rem_ff[CELL_WIDTH-1];
   assign quo_msb_out = quo_ff[CELL_WIDTH-1];
   assign borrow_out  = diff_ext[CELL_WIDTH];
   assign rem_out     = rem_ff;
   assign quo_out     = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/sud64_ctrl.sv -----
// Sequencer of the divider: operand magnitudes, step count, sign fix-up and result register.
// Depends on sud64_pkg for codes, widths and the chain structs.
`default_nettype none

module sud64_ctrl
   import sud64_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [OP_WIDTH-1:0]   req_operation,
   input  wire logic [DATA_WIDTH-1:0] req_dividend,
   input  wire logic [DATA_WIDTH-1:0] req_divisor,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_WIDTH-1:0]      rsp_answer,
   output logic                       rsp_divide_by_zero,
   input  wire chain_status_type      chain_status,
   input  wire logic [DATA_WIDTH-1:0] rem_word,
   input  wire logic [DATA_WIDTH-1:0] quo_word,
   output cell_ctrl_type              cell_ctrl,
   output logic [DATA_WIDTH-1:0]      load_num,
   output logic [DATA_WIDTH-1:0]      load_den
);

   div_state_type              state_ff, state_in;
   logic [STEP_COUNT_BITS-1:0] count_ff, count_in;
   logic                       want_rem_ff, want_rem_in;
   logic                       negate_ff, negate_in;
   logic                       dbz_ff, dbz_in;
   logic                       valid_ff, valid_in;
   logic [DATA_WIDTH-1:0]      answer_ff, answer_in;
   logic                       answer_dbz_ff, answer_dbz_in;
   logic                       accept;
   logic                       is_signed;
   logic                       want_rem;
   logic                       num_neg;
   logic                       den_neg;
   logic                       out_free;
   logic [DATA_WIDTH-1:0]      picked;

   always_comb begin
      is_signed = (req_operation == OP_SIGNED_QUOT) || (req_operation == OP_SIGNED_REM);
      want_rem  = (req_operation == OP_UNSIGNED_REM) || (req_operation == OP_SIGNED_REM);
      num_neg   = is_signed && req_dividend[DATA_WIDTH-1];
      den_neg   = is_signed && req_divisor[DATA_WIDTH-1];
      load_num  = num_neg ? (~req_dividend + 1'b1) : req_dividend;
      load_den  = den_neg ? (~req_divisor + 1'b1) : req_divisor;
      accept    = req_tvalid && req_tready;
      out_free  = !valid_ff || rsp_tready;
      picked    = want_rem_ff ? rem_word : quo_word;
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cell_ctrl.load = accept;
      cell_ctrl.step = (state_ff == ST_RUN);
      // A set top bit before the shift means the shifted remainder exceeds any divisor.
      cell_ctrl.fits = chain_status.rem_msb || !chain_status.borrow;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      want_rem_in   = want_rem_ff;
      negate_in     = negate_ff;
      dbz_in        = dbz_ff;
      answer_in     = answer_ff;
      answer_dbz_in = answer_dbz_ff;
      valid_in      = valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               want_rem_in = want_rem;
               negate_in   = want_rem ? num_neg : (num_neg ^ den_neg);
               dbz_in      = (req_divisor == '0);
               count_in    = '0;
               state_in    = (req_divisor == '0) ? ST_FIX : ST_RUN;
            end
         end
         ST_RUN: begin
            count_in = count_ff + 1'b1;
            if (count_ff == STEP_COUNT_BITS'(DATA_WIDTH - 1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (out_free) begin
               if (dbz_ff) begin
                  answer_in = '0;
               end else begin
                  answer_in = negate_ff ? (~picked + 1'b1) : picked;
               end
               // The flag travels with the answer so a new beat cannot disturb it.
               answer_dbz_in = dbz_ff;
               valid_in      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
      end
      want_rem_ff   <= want_rem_in;
      negate_ff     <= negate_in;
      dbz_ff        <= dbz_in;
      answer_ff     <= answer_in;
      answer_dbz_ff <= answer_dbz_in;
   end

   assign rsp_tvalid         = valid_ff;
   assign rsp_answer         = answer_ff;
   assign rsp_divide_by_zero = answer_dbz_ff;

endmodule

`default_nettype wire
